### rtl/core/lfu_pkg.sv
// lfu_pkg: shared types and constants for the LFU page replacement block.
// Holds the channel payload structs and the cell chain control structs.
// No dependencies.
package lfu_pkg;

	localparam int PAGE_FIELD_W  = 16;
	localparam int SLOT_FIELD_W  = 4;
	localparam int FAULT_W       = 32;
	localparam int FRAMES_CFG_W  = 5;
	localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 5'd16;

	// access request payload
	typedef struct packed {
		logic [PAGE_FIELD_W-1:0] page;
	} access_t;

	// result payload
	typedef struct packed {
		logic                    hit;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    evicted_valid;
		logic [PAGE_FIELD_W-1:0] evicted_page;
		logic [FAULT_W-1:0]      fault_count;
	} result_t;

	// configuration write payload
	typedef struct packed {
		logic [FRAMES_CFG_W-1:0] frames_in_use;
	} cfg_t;

	// search token flags travelling down the cell chain
	typedef struct packed {
		logic go;          // token carries a live request
		logic hit;         // a matching resident page was seen
		logic empty_found; // an empty frame was seen
		logic best_set;    // best_* holds a candidate
	} tok_flags_t;

	// update broadcast from the chain tail to all cells
	typedef struct packed {
		logic en;   // write the addressed cell
		logic fill; // 1: load new page, count 1; 0: bump count
	} upd_ctl_t;

endpackage

### rtl/core/lfu_stream_if.sv
// lfu_stream_if: valid/ready channel with a typed payload.
// Depends on nothing; payload type set per instance.
interface lfu_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/lfu_cell.sv
// lfu_cell: one page frame of the LFU table plus one stage of the search chain.
// Depends on lfu_pkg.
module lfu_cell import lfu_pkg::*; #(
	parameter int INDEX      = 0,
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16,
	parameter int COUNT_BITS = 16,
	localparam int IDX_W     = $clog2(NUM_FRAMES),
	localparam int NW        = $clog2(NUM_FRAMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NW-1:0]         n_act,
	// token from the previous stage
	input  tok_flags_t            prev_flags,
	input  logic [PAGE_BITS-1:0]  prev_page,
	input  logic [IDX_W-1:0]      prev_hit_idx,
	input  logic [IDX_W-1:0]      prev_empty_idx,
	input  logic [IDX_W-1:0]      prev_best_idx,
	input  logic [COUNT_BITS-1:0] prev_best_cnt,
	input  logic [PAGE_BITS-1:0]  prev_best_page,
	// token to the next stage (registered)
	output tok_flags_t            next_flags,
	output logic [PAGE_BITS-1:0]  next_page,
	output logic [IDX_W-1:0]      next_hit_idx,
	output logic [IDX_W-1:0]      next_empty_idx,
	output logic [IDX_W-1:0]      next_best_idx,
	output logic [COUNT_BITS-1:0] next_best_cnt,
	output logic [PAGE_BITS-1:0]  next_best_page,
	// update broadcast
	input  upd_ctl_t              upd,
	input  logic [IDX_W-1:0]      upd_idx,
	input  logic [PAGE_BITS-1:0]  upd_page
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic                  valid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  active;
	logic                  sel;
	tok_flags_t            flags_d;
	logic [IDX_W-1:0]      hit_idx_d;
	logic [IDX_W-1:0]      empty_idx_d;
	logic [IDX_W-1:0]      best_idx_d;
	logic [COUNT_BITS-1:0] best_cnt_d;
	logic [PAGE_BITS-1:0]  best_page_d;

	// merge this frame into the passing token
	always_comb begin
		active      = 32'(n_act) > INDEX;
		flags_d     = prev_flags;
		hit_idx_d   = prev_hit_idx;
		empty_idx_d = prev_empty_idx;
		best_idx_d  = prev_best_idx;
		best_cnt_d  = prev_best_cnt;
		best_page_d = prev_best_page;
		if (active) begin
			if (!prev_flags.hit && valid_q && page_q == prev_page) begin
				flags_d.hit = 1'b1;
				hit_idx_d   = MY_IDX;
			end
			if (!prev_flags.empty_found && !valid_q) begin
				flags_d.empty_found = 1'b1;
				empty_idx_d         = MY_IDX;
			end
			// strict less-than keeps the lowest index on ties
			if (!prev_flags.best_set || count_q < prev_best_cnt) begin
				flags_d.best_set = 1'b1;
				best_idx_d       = MY_IDX;
				best_cnt_d       = count_q;
				best_page_d      = page_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_flags <= '0;
		end else begin
			next_flags <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		next_page      <= prev_page;
		next_hit_idx   <= hit_idx_d;
		next_empty_idx <= empty_idx_d;
		next_best_idx  <= best_idx_d;
		next_best_cnt  <= best_cnt_d;
		next_best_page <= best_page_d;
	end

	assign sel = upd.en && upd_idx == MY_IDX;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (sel) begin
			if (upd.fill) begin
				valid_q <= 1'b1;
				count_q <= COUNT_BITS'(1);
			end else if (!(&count_q)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && upd.fill) begin
			page_q <= upd_page;
		end
	end

endmodule

### rtl/core/lfu_page_replacement.sv
// lfu_page_replacement: LFU page frame table built as a chain of frame cells.
// Depends on lfu_pkg, lfu_stream_if and lfu_cell.
//
//  channel  | dir | payload                                               | handshake
//  ---------+-----+-------------------------------------------------------+----------
//  access   | in  | page                                                  | valid/ready
//  result   | out | hit, slot, evicted_valid, evicted_page, fault_count   | valid/ready
//  cfg      | in  | frames_in_use                                         | valid/ready
//
// One request at a time: the chain head register loads the request, the search
// token walks the frame chain one cell per cycle, then the tail applies the update
// and registers the result, which then moves into the output register.
// Reset empties every frame, zeroes the fault total and sets frames_in_use to 16.
// A stalled result holds the block busy only until it reaches the output
// register; the next request is taken while that result waits. cfg is always ready.
module lfu_page_replacement import lfu_pkg::*; #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lfu_stream_if.sink   access,
	lfu_stream_if.source result,
	lfu_stream_if.sink   cfg
);

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int NW    = $clog2(NUM_FRAMES + 1);

	// configuration
	logic [FRAMES_CFG_W-1:0] frames_q;
	logic [NW-1:0]           n_act;

	// chain head
	tok_flags_t              head_flags_q;
	logic [PAGE_BITS-1:0]    head_page_q;

	// token wires; stage k feeds cell k, stage NUM_FRAMES is the tail
	tok_flags_t              tok_flags     [NUM_FRAMES+1];
	logic [PAGE_BITS-1:0]    tok_page      [NUM_FRAMES+1];
	logic [IDX_W-1:0]        tok_hit_idx   [NUM_FRAMES+1];
	logic [IDX_W-1:0]        tok_empty_idx [NUM_FRAMES+1];
	logic [IDX_W-1:0]        tok_best_idx  [NUM_FRAMES+1];
	logic [COUNT_BITS-1:0]   tok_best_cnt  [NUM_FRAMES+1];
	logic [PAGE_BITS-1:0]    tok_best_page [NUM_FRAMES+1];
	logic [NUM_FRAMES:0]     go_vec;

	// tail decisions and update broadcast
	tok_flags_t              tail;
	logic [IDX_W-1:0]        slot_idx;
	logic                    evict;
	logic [FAULT_W-1:0]      fault_next;
	upd_ctl_t                upd;

	// control and result registers
	logic                    busy_q;
	logic [FAULT_W-1:0]      fault_q;
	result_t                 pend_q;
	logic                    pend_v_q;
	result_t                 out_q;
	logic                    out_v_q;
	logic                    move;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg.valid) begin
			frames_q <= cfg.data.frames_in_use;
		end
	end

	// zero acts as one, anything above the table size as the table size
	always_comb begin
		if (frames_q == '0) begin
			n_act = NW'(1);
		end else if (32'(frames_q) > NUM_FRAMES) begin
			n_act = NW'(NUM_FRAMES);
		end else begin
			n_act = NW'(frames_q);
		end
	end

	// ---------------- request intake ----------------
	assign access.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_flags_q <= '0;
		end else begin
			head_flags_q <= '{go: access.valid && !busy_q, default: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (access.valid && !busy_q) begin
			head_page_q <= PAGE_BITS'(access.data.page);
		end
	end

	assign tok_flags[0]     = head_flags_q;
	assign tok_page[0]      = head_page_q;
	assign tok_hit_idx[0]   = '0;
	assign tok_empty_idx[0] = '0;
	assign tok_best_idx[0]  = '0;
	assign tok_best_cnt[0]  = '0;
	assign tok_best_page[0] = '0;

	// ---------------- frame chain ----------------
	for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
		lfu_cell #(
			.INDEX      (k),
			.NUM_FRAMES (NUM_FRAMES),
			.PAGE_BITS  (PAGE_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.n_act          (n_act),
			.prev_flags     (tok_flags[k]),
			.prev_page      (tok_page[k]),
			.prev_hit_idx   (tok_hit_idx[k]),
			.prev_empty_idx (tok_empty_idx[k]),
			.prev_best_idx  (tok_best_idx[k]),
			.prev_best_cnt  (tok_best_cnt[k]),
			.prev_best_page (tok_best_page[k]),
			.next_flags     (tok_flags[k+1]),
			.next_page      (tok_page[k+1]),
			.next_hit_idx   (tok_hit_idx[k+1]),
			.next_empty_idx (tok_empty_idx[k+1]),
			.next_best_idx  (tok_best_idx[k+1]),
			.next_best_cnt  (tok_best_cnt[k+1]),
			.next_best_page (tok_best_page[k+1]),
			.upd            (upd),
			.upd_idx        (slot_idx),
			.upd_page       (tok_page[NUM_FRAMES])
		);
	end

	for (genvar k = 0; k <= NUM_FRAMES; k++) begin : g_go
		assign go_vec[k] = tok_flags[k].go;
	end

	// ---------------- tail: pick the frame, broadcast the update ----------------
	assign tail = tok_flags[NUM_FRAMES];

	// hit wins, then the first empty frame, then the least-used frame
	always_comb begin
		if (tail.hit) begin
			slot_idx = tok_hit_idx[NUM_FRAMES];
		end else if (tail.empty_found) begin
			slot_idx = tok_empty_idx[NUM_FRAMES];
		end else begin
			slot_idx = tok_best_idx[NUM_FRAMES];
		end
		evict      = !tail.hit && !tail.empty_found;
		fault_next = (!tail.hit && !(&fault_q)) ? fault_q + 1'b1 : fault_q;
		upd.en     = tail.go;
		upd.fill   = !tail.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (tail.go) begin
			fault_q <= fault_next;
		end
	end

	// ---------------- result hand-off ----------------
	assign move = pend_v_q && (!out_v_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (access.valid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tail.go) begin
				pend_v_q <= 1'b1;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.go) begin
			pend_q.hit           <= tail.hit;
			pend_q.slot          <= SLOT_FIELD_W'(slot_idx);
			pend_q.evicted_valid <= evict;
			pend_q.evicted_page  <= evict ? PAGE_FIELD_W'(tok_best_page[NUM_FRAMES])
						      : '0;
			pend_q.fault_count   <= fault_next;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	// ---------------- assertions ----------------
	// at most one request in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(go_vec) <= 1)
		else $error("more than one search token in the frame chain");

	// a token only reaches the tail while a request is outstanding
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.go |-> busy_q && !pend_v_q)
		else $error("token at chain tail without an outstanding request");

	// a pending result keeps intake closed
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> busy_q)
		else $error("pending result while intake open");

	// eviction is only reported on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !(pend_q.hit && pend_q.evicted_valid))
		else $error("eviction reported on a hit");

	// the fault total never falls
	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 fault_q >= $past(fault_q))
		else $error("fault total decreased");

endmodule
